FILE: src/nvme_queue_pair_host_engine_macros.svh
// ----------------------------------------------------------------------------
// NVMe queue pair engine assertion macros
// Shared concurrent assertion shorthands, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef NVME_QUEUE_PAIR_HOST_ENGINE_MACROS_SVH
`define NVME_QUEUE_PAIR_HOST_ENGINE_MACROS_SVH

// checked only out of reset
`define NQP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked in and out of reset
`define NQP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/nqp_pkg.sv
// ----------------------------------------------------------------------------
// nqp_pkg
// Types, constants and the control store of the NVMe queue pair engine.
// ----------------------------------------------------------------------------
package nqp_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int IN_DATA_W  = 232;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 72;
	localparam int OUT_USER_W = 2;
	localparam int ADDR_W     = 19;
	localparam int STATUS_W   = 15;
	localparam int CID_W      = 16;
	localparam int EXP_W      = 4;
	localparam int PC_W       = 5;

	localparam logic [ADDR_W-1:0] DB_BASE = 19'h01000;

	// result kinds
	localparam logic [1:0] KIND_CMD      = 2'd0;
	localparam logic [1:0] KIND_DB       = 2'd1;
	localparam logic [1:0] KIND_STATUS   = 2'd2;
	localparam logic [1:0] KIND_NOTREADY = 2'd3;

	// program entry points and branch target
	localparam logic [PC_W-1:0] PC_SUBMIT    = 5'd0;
	localparam logic [PC_W-1:0] PC_TAIL_DB   = 5'd16;
	localparam logic [PC_W-1:0] PC_CHECK     = 5'd17;
	localparam logic [PC_W-1:0] PC_HEAD_DB   = 5'd18;
	localparam logic [PC_W-1:0] PC_STATUS    = 5'd19;
	localparam logic [PC_W-1:0] PC_NOTREADY  = 5'd20;

	typedef struct packed {
		logic            emit;     // step produces a result
		logic [1:0]      kind;
		logic [3:0]      dw_idx;   // command dword index
		logic            is_head;  // doorbell/update targets the head
		logic            upd;      // advance tail or head
		logic            last;
		logic            done;     // final step of the routine
		logic            jmp;      // branch on phase mismatch
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic       fire;          // step executes this cycle
		ctrl_word_t cw;
	} step_t;

	function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		w = '0;
		w.done = 1'b1;
		if (pc < PC_TAIL_DB) begin
			w.emit   = 1'b1;
			w.kind   = KIND_CMD;
			w.dw_idx = pc[3:0];
			w.done   = 1'b0;
		end else begin
			unique case (pc)
				PC_TAIL_DB: begin
					w.emit = 1'b1;
					w.kind = KIND_DB;
					w.upd  = 1'b1;
					w.last = 1'b1;
				end
				PC_CHECK: begin
					w.done   = 1'b0;
					w.jmp    = 1'b1;
					w.target = PC_NOTREADY;
				end
				PC_HEAD_DB: begin
					w.emit    = 1'b1;
					w.kind    = KIND_DB;
					w.is_head = 1'b1;
					w.upd     = 1'b1;
					w.done    = 1'b0;
				end
				PC_STATUS: begin
					w.emit = 1'b1;
					w.kind = KIND_STATUS;
					w.last = 1'b1;
				end
				PC_NOTREADY: begin
					w.emit = 1'b1;
					w.kind = KIND_NOTREADY;
					w.last = 1'b1;
				end
				default: begin
					w.done = 1'b1;
				end
			endcase
		end
		return w;
	endfunction

endpackage

FILE: src/nvme_queue_pair_host_engine.sv
// ----------------------------------------------------------------------------
// nvme_queue_pair_host_engine
// Host side of an NVMe admin and I/O submission/completion queue pair.
// ----------------------------------------------------------------------------
// A submit transaction (s_tuser func = 0) produces sixteen command dword
// writes into the submission slot at the tail, then the tail doorbell write
// (tlast). A completion check (func = 1) compares the phase bit of the given
// completion dword3 with the expected phase: on a match it gives the head
// doorbell write and then the status (tlast); otherwise one not-ready result.
// A small control store sequences each routine, one step per cycle unless an
// emitting step waits for the output register; a result is emitted on each
// emitting step, held in a single output register. The next transaction is
// taken in the cycle the current routine ends, so the rate is set by the step
// counter walking the program; an emitting step waits while a result is held
// with m_tready low. Queue wrap follows QUEUE_DEPTH; a full queue is not
// detected. cfg_ready is always high.
// ----------------------------------------------------------------------------
module nvme_queue_pair_host_engine #(
	parameter int QUEUE_DEPTH = nqp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input item
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// opcode[7:0], namespace_id[39:8], buffer_address[103:40],
	// dword_ten[135:104], dword_eleven[167:136], dword_twelve[199:168],
	// completion_word[231:200]
	input  logic [nqp_pkg::IN_DATA_W-1:0]   s_tdata,
	// func[0], queue_id[1]
	input  logic [nqp_pkg::IN_USER_W-1:0]   s_tuser,
	// results
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// address[18:0], value[50:19], status_code[65:51], success[66], zero[71:67]
	output logic [nqp_pkg::OUT_DATA_W-1:0]  m_tdata,
	// kind[1:0]
	output logic [nqp_pkg::OUT_USER_W-1:0]  m_tuser,
	output logic                            m_tlast,
	// doorbell_stride_exponent write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nqp_pkg::EXP_W-1:0]       cfg_data
);
	import nqp_pkg::*;

	step_t step;
	logic  in_accept;
	logic  mismatch;
	logic  out_free;

	assign in_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// program counter and control store
	nqp_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_func   (s_tuser[0]),
		.out_free  (out_free),
		.mismatch  (mismatch),
		.ready     (s_tready),
		.step      (step)
	);

	// queue pointers, formatting and output register
	nqp_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.step      (step),
		.mismatch  (mismatch),
		.out_free  (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

FILE: src/nqp_sequencer.sv
// ----------------------------------------------------------------------------
// nqp_sequencer
// Step counter over the control store, with the phase-mismatch branch.
// ----------------------------------------------------------------------------
module nqp_sequencer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_accept,
	input  logic          in_func,
	input  logic          out_free,
	input  logic          mismatch,
	output logic          ready,
	output nqp_pkg::step_t step
);
	import nqp_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            busy_q;
	ctrl_word_t      cw;
	logic            fire;
	logic            finish;

	assign cw     = ucode_rom(pc_q);
	assign fire   = busy_q && (!cw.emit || out_free);
	assign finish = fire && cw.done;
	// next item may enter on the cycle the current routine ends
	assign ready  = !busy_q || finish;

	assign step.fire = fire;
	assign step.cw   = cw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= PC_SUBMIT;
			busy_q <= 1'b0;
		end else begin
			if (in_accept) begin
				pc_q   <= in_func ? PC_CHECK : PC_SUBMIT;
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (fire) begin
				if (cw.jmp && mismatch)
					pc_q <= cw.target;
				else
					pc_q <= pc_q + 5'd1;
			end
		end
	end

endmodule

FILE: src/nqp_datapath.sv
// ----------------------------------------------------------------------------
// nqp_datapath
// Item register, queue pointers, dword and doorbell formatting, output stage.
// ----------------------------------------------------------------------------
module nqp_datapath #(
	parameter int QUEUE_DEPTH = nqp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_accept,
	input  logic [nqp_pkg::IN_DATA_W-1:0]   in_data,
	input  logic [nqp_pkg::IN_USER_W-1:0]   in_user,
	input  logic                            cfg_we,
	input  logic [nqp_pkg::EXP_W-1:0]       cfg_data,
	input  nqp_pkg::step_t                  step,
	output logic                            mismatch,
	output logic                            out_free,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [nqp_pkg::OUT_DATA_W-1:0]  out_data,
	output logic [nqp_pkg::OUT_USER_W-1:0]  out_user,
	output logic                            out_last
);
	import nqp_pkg::*;

	localparam int SLOT_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(QUEUE_DEPTH - 1);

	// captured item
	logic        qid_q;
	logic [7:0]  opcode_q;
	logic [31:0] nsid_q;
	logic [63:0] buf_q;
	logic [31:0] d10_q;
	logic [31:0] d11_q;
	logic [31:0] d12_q;
	logic [31:0] cpl_q;

	// queue state
	logic [SLOT_W-1:0] tail_q  [2];
	logic [SLOT_W-1:0] head_q  [2];
	logic [1:0]        phase_q;
	logic [CID_W-1:0]  cid_q;
	logic [EXP_W-1:0]  exp_q;

	// output stage
	logic                valid_q;
	logic [1:0]          kind_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [31:0]         value_q;
	logic [STATUS_W-1:0] st_q;
	logic                ok_q;
	logic                last_q;

	logic [SLOT_W-1:0]   slot;
	logic [SLOT_W-1:0]   nxt_tail;
	logic [SLOT_W-1:0]   nxt_head;
	logic [CID_W-1:0]    nxt_cid;
	logic [STATUS_W-1:0] status;
	logic [31:0]         dword;
	logic [ADDR_W-1:0]   db_addr;
	logic [1:0]          kind_d;
	logic [ADDR_W-1:0]   addr_d;
	logic [31:0]         value_d;
	logic [STATUS_W-1:0] st_d;
	logic                ok_d;
	logic                emit;

	assign slot     = tail_q[qid_q];
	assign nxt_tail = (tail_q[qid_q] == SLOT_MAX) ? '0 : tail_q[qid_q] + SLOT_W'(1);
	assign nxt_head = (head_q[qid_q] == SLOT_MAX) ? '0 : head_q[qid_q] + SLOT_W'(1);
	assign nxt_cid  = (cid_q == '1) ? CID_W'(1) : cid_q + CID_W'(1);
	assign status   = cpl_q[31:17];
	assign mismatch = cpl_q[16] != phase_q[qid_q];

	// doorbell offset: base + (2*qid + head) * (4 << exp)
	assign db_addr = DB_BASE
		+ (ADDR_W'({qid_q, step.cw.is_head}) << (5'(exp_q) + 5'd2));

	always_comb begin
		unique case (step.cw.dw_idx)
			4'd0:    dword = {cid_q, 8'h00, opcode_q};
			4'd1:    dword = nsid_q;
			4'd6:    dword = buf_q[31:0];
			4'd7:    dword = buf_q[63:32];
			4'd10:   dword = d10_q;
			4'd11:   dword = d11_q;
			4'd12:   dword = d12_q;
			default: dword = '0;
		endcase
	end

	always_comb begin
		kind_d  = step.cw.kind;
		addr_d  = '0;
		value_d = '0;
		st_d    = '0;
		ok_d    = 1'b0;
		unique case (step.cw.kind)
			KIND_CMD: begin
				addr_d  = ADDR_W'({slot, step.cw.dw_idx});
				value_d = dword;
			end
			KIND_DB: begin
				addr_d  = db_addr;
				value_d = step.cw.is_head ? 32'(nxt_head) : 32'(nxt_tail);
			end
			KIND_STATUS: begin
				st_d = status;
				ok_d = status == '0;
			end
			KIND_NOTREADY: begin
				kind_d = KIND_NOTREADY;
			end
		endcase
	end

	assign emit     = step.fire && step.cw.emit;
	assign out_free = !valid_q || out_ready;

	// item capture
	always_ff @(posedge clk) begin
		if (in_accept) begin
			qid_q    <= in_user[1];
			opcode_q <= in_data[7:0];
			nsid_q   <= in_data[39:8];
			buf_q    <= in_data[103:40];
			d10_q    <= in_data[135:104];
			d11_q    <= in_data[167:136];
			d12_q    <= in_data[199:168];
			cpl_q    <= in_data[231:200];
		end
	end

	// queue state and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q[0] <= '0;
			tail_q[1] <= '0;
			head_q[0] <= '0;
			head_q[1] <= '0;
			phase_q   <= 2'b11;
			cid_q     <= CID_W'(1);
			exp_q     <= '0;
		end else begin
			if (cfg_we)
				exp_q <= cfg_data;
			if (step.fire && step.cw.upd) begin
				if (step.cw.is_head) begin
					head_q[qid_q] <= nxt_head;
					if (nxt_head == '0)
						phase_q[qid_q] <= !phase_q[qid_q];
				end else begin
					tail_q[qid_q] <= nxt_tail;
					cid_q         <= nxt_cid;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= kind_d;
			addr_q  <= addr_d;
			value_q <= value_d;
			st_q    <= st_d;
			ok_q    <= ok_d;
			last_q  <= step.cw.last;
		end
	end

	assign out_valid = valid_q;
	assign out_user  = kind_q;
	assign out_last  = last_q;
	assign out_data  = {5'd0, ok_q, st_q, value_q, addr_q};

endmodule

FILE: src/nqp_checker.sv
// ----------------------------------------------------------------------------
// nqp_checker
// Port-level checks of the queue pair engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "nvme_queue_pair_host_engine_macros.svh"

module nqp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [nqp_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [nqp_pkg::OUT_USER_W-1:0]  m_tuser,
	input logic                            m_tlast
);
	import nqp_pkg::*;

	`NQP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
	`NQP_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "input taken twice in a row")
	`NQP_ASSERT(a_notready_form, m_tvalid && m_tuser == KIND_NOTREADY |-> m_tlast && m_tdata == '0, "bad not-ready result")
	`NQP_ASSERT(a_status_form, m_tvalid && m_tuser == KIND_STATUS |-> m_tlast && (m_tdata[66] == (m_tdata[65:51] == '0)), "bad status result")
	`NQP_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind nvme_queue_pair_host_engine nqp_checker u_chk (.*);
